FILE: rtl/core/mfr_pkg.sv
// ----------------------------------------------------------------------------
// mfr_pkg
// Types and constants for the motor frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package mfr_pkg;

  localparam int unsigned FRAME_LEN = 10;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN);

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [7:0]       byte_t;
  typedef logic [1:0]       status_t;

  localparam byte_t HEADER_BYTE = 8'hFF;

  // byte positions within a frame
  localparam pos_t POS_HDR0  = pos_t'(0);
  localparam pos_t POS_HDR1  = pos_t'(1);
  localparam pos_t POS_ANG_H = pos_t'(2);
  localparam pos_t POS_ANG_L = pos_t'(3);
  localparam pos_t POS_KD    = pos_t'(4);
  localparam pos_t POS_KI    = pos_t'(5);
  localparam pos_t POS_KP    = pos_t'(6);
  localparam pos_t POS_SCALE = pos_t'(7);
  localparam pos_t POS_SUM   = pos_t'(8);
  localparam pos_t POS_LAST  = pos_t'(FRAME_LEN - 1);

  // frame status codes
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_BAD_HDR = 2'd1;
  localparam status_t ST_BAD_SUM = 2'd2;

endpackage

`default_nettype wire

FILE: rtl/core/motor_frame_receiver.sv
// ----------------------------------------------------------------------------
// motor_frame_receiver
// Collects ten-byte motor frames, checks header and additive checksum and
// latches angle and gains from good frames.
// ----------------------------------------------------------------------------
// Result: out_valid is registered and rises in the cycle after the tenth byte of a frame is accepted.
// Throughput: one byte per cycle; the tenth byte waits only while the previous
//   result is still held and out_ready is low.
// Reset: synchronous, active low; byte position, result valid and held angle
//   and gains clear to zero.
`default_nettype none

module motor_frame_receiver
  import mfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_frame_status,
  output logic [15:0]      out_angle,
  output logic [7:0]       out_gain_d,
  output logic [7:0]       out_gain_i,
  output logic [7:0]       out_gain_p,
  output logic [7:0]       out_gain_scale
);

  pos_t    pos_r, pos_nxt;
  logic    hdr_ok_r, hdr_ok_nxt;
  byte_t   sum_r, sum_nxt;
  byte_t   chk_r;
  byte_t   ang_h_r, ang_l_r, kd_r, ki_r, kp_r, scale_r;
  logic    out_valid_r, out_valid_nxt;
  status_t status_r, status_nxt;
  logic [15:0] held_angle_r;
  byte_t   held_d_r, held_i_r, held_p_r, held_scale_r;

  logic    in_acc, is_last, frame_done, sum_good;

  assign is_last    = (pos_r == POS_LAST);
  assign in_ready   = !is_last || !out_valid_r || out_ready;
  assign in_acc     = in_valid && in_ready;
  assign frame_done = in_acc && is_last;

  // inverted checksum arrives last, compared straight off the input
  assign sum_good = (chk_r == sum_r) && (in_rx_byte == ~sum_r);

  always_comb begin
    pos_nxt    = pos_r;
    hdr_ok_nxt = hdr_ok_r;
    sum_nxt    = sum_r;
    if (in_acc) begin
      pos_nxt = is_last ? POS_HDR0 : pos_r + pos_t'(1);
      if (pos_r == POS_HDR0) begin
        hdr_ok_nxt = (in_rx_byte == HEADER_BYTE);
        sum_nxt    = '0;
      end else if (pos_r == POS_HDR1) begin
        hdr_ok_nxt = hdr_ok_r && (in_rx_byte == HEADER_BYTE);
      end else if (pos_r >= POS_ANG_H && pos_r <= POS_SCALE) begin
        sum_nxt = sum_r + in_rx_byte;
      end
    end
  end

  always_comb begin
    if (!hdr_ok_r) begin
      status_nxt = ST_BAD_HDR;
    end else if (!sum_good) begin
      status_nxt = ST_BAD_SUM;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (frame_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= POS_HDR0;
      hdr_ok_r     <= 1'b0;
      sum_r        <= '0;
      out_valid_r  <= 1'b0;
      status_r     <= ST_OK;
      held_angle_r <= '0;
      held_d_r     <= '0;
      held_i_r     <= '0;
      held_p_r     <= '0;
      held_scale_r <= '0;
    end else begin
      pos_r       <= pos_nxt;
      hdr_ok_r    <= hdr_ok_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (frame_done) begin
        status_r <= status_nxt;
        if (status_nxt == ST_OK) begin
          held_angle_r <= {ang_h_r, ang_l_r};
          held_d_r     <= kd_r;
          held_i_r     <= ki_r;
          held_p_r     <= kp_r;
          held_scale_r <= scale_r;
        end
      end
    end
  end

  // frame payload capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      case (pos_r)
        POS_ANG_H: ang_h_r <= in_rx_byte;
        POS_ANG_L: ang_l_r <= in_rx_byte;
        POS_KD:    kd_r    <= in_rx_byte;
        POS_KI:    ki_r    <= in_rx_byte;
        POS_KP:    kp_r    <= in_rx_byte;
        POS_SCALE: scale_r <= in_rx_byte;
        POS_SUM:   chk_r   <= in_rx_byte;
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_status = status_r;
  assign out_angle        = held_angle_r;
  assign out_gain_d       = held_d_r;
  assign out_gain_i       = held_i_r;
  assign out_gain_p       = held_p_r;
  assign out_gain_scale   = held_scale_r;

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("byte position out of range");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid && in_ready && pos_r == POS_LAST))
    else $error("result raised without a completed frame");

  a_held_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(held_angle_r) |-> (out_valid_r && status_r == ST_OK))
    else $error("held angle changed on a rejected frame");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (status_r == ST_OK || status_r == ST_BAD_HDR ||
                     status_r == ST_BAD_SUM))
    else $error("illegal frame status");
`endif

endmodule

`default_nettype wire
